@@ rtl/core/tcw_pkg.sv @@
package tcw_pkg;

  // input command kinds
  localparam logic [1:0] KIND_PUT    = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // special character codes
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] RETURN_CODE  = 8'd13;
  localparam logic [7:0] SPACE_CODE   = 8'h20;

  // blank cell after reset: space, light grey on black
  localparam logic [15:0] RESET_BLANK = 16'h0720;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_RETURN,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } tcw_op_e;

  typedef struct packed {
    tcw_op_e     op;
    logic [7:0]  char_code;
    logic [7:0]  color;
    logic [10:0] read_index;
    logic        read_ok;
  } tcw_cmd_t;

endpackage

@@ rtl/core/text_console_writer_core.sv @@
// an accepted beat is queued and executed from the queue head; put, return,
//   newline without scroll and unused kinds register their result, a read via ST_READ
// throughput: those simple beats sustain one per cycle through the single store write port
//   while no result waits on out_ready; clear and scroll sweep the store one cell per cycle
// reset: cursor homes and a blanking sweep over all ROWS*COLUMNS cells (2000 by default)
//   fills the store with 0x0720 while input is held off
module text_console_writer_core #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  color_i,
  input  logic [10:0] read_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] cell_value_o,
  output logic [4:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;

  logic              push;
  logic              q_full;
  logic              init_busy;
  logic              pop;
  logic              cmd_valid;
  tcw_pkg::tcw_cmd_t push_cmd;
  tcw_pkg::tcw_cmd_t cmd;

  // front: accept and classify beats
  tcw_front #(
    .CELLS (CELLS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .color_i      (color_i),
    .read_index_i (read_index_i),
    .q_full_i     (q_full),
    .init_busy_i  (init_busy),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // command queue
  tcw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_cmd_i  (push_cmd),
    .full_o      (q_full),
    .pop_valid_o (cmd_valid),
    .pop_cmd_o   (cmd),
    .pop_i       (pop)
  );

  // back: store, cursor and result slot
  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .pop_o        (pop),
    .init_busy_o  (init_busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_value_o (cell_value_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o)
  );

endmodule

@@ rtl/core/tcw_front.sv @@
module tcw_front #(
  parameter int unsigned CELLS = 2000
) (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [7:0]        char_code_i,
  input  logic [7:0]        color_i,
  input  logic [10:0]       read_index_i,
  input  logic              q_full_i,
  input  logic              init_busy_i,
  output logic              push_o,
  output tcw_pkg::tcw_cmd_t cmd_o
);

  // hold off input while the queue is full or the store is being initialized
  assign in_ready_o = !q_full_i && !init_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  // classify the incoming beat into a back-end operation
  always_comb begin
    cmd_o.char_code  = char_code_i;
    cmd_o.color      = color_i;
    cmd_o.read_index = read_index_i;
    cmd_o.read_ok    = (32'(read_index_i) < 32'(CELLS));
    unique case (kind_i)
      tcw_pkg::KIND_PUT: begin
        if (char_code_i == tcw_pkg::NEWLINE_CODE) begin
          cmd_o.op = tcw_pkg::OP_NEWLINE;
        end else if (char_code_i == tcw_pkg::RETURN_CODE) begin
          cmd_o.op = tcw_pkg::OP_RETURN;
        end else begin
          cmd_o.op = tcw_pkg::OP_PUT;
        end
      end
      tcw_pkg::KIND_CLEAR:  cmd_o.op = tcw_pkg::OP_CLEAR;
      tcw_pkg::KIND_READ:   cmd_o.op = tcw_pkg::OP_READ;
      tcw_pkg::KIND_UNUSED: cmd_o.op = tcw_pkg::OP_NOP;
      default:              cmd_o.op = tcw_pkg::OP_NOP;
    endcase
  end

endmodule

@@ rtl/core/tcw_queue.sv @@
module tcw_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tcw_pkg::tcw_cmd_t push_cmd_i,
  output logic              full_o,
  output logic              pop_valid_o,
  output tcw_pkg::tcw_cmd_t pop_cmd_o,
  input  logic              pop_i
);

  localparam int unsigned CNT_W = tcw_pkg::QPTR_W + 1;

  tcw_pkg::tcw_cmd_t              entry_q [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [tcw_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]               count_q, count_d;
  logic                           do_push, do_pop;

  assign full_o      = (count_q == CNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_cmd_o   = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && pop_valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + tcw_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + tcw_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/core/tcw_back.sv @@
module tcw_back #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  tcw_pkg::tcw_cmd_t cmd_i,
  output logic              pop_o,
  output logic              init_busy_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       cell_value_o,
  output logic [4:0]        cursor_row_o,
  output logic [6:0]        cursor_col_o
);

  localparam int unsigned CELLS  = ROWS * COLUMNS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILL  = 3'd1;
  localparam logic [2:0] ST_PRIME = 3'd2;
  localparam logic [2:0] ST_COPY  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;

  logic [15:0]       screen_mem_q [CELLS];
  logic [15:0]       rd_data_q;

  logic [2:0]        state_q, state_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [15:0]       fill_q, fill_d;
  logic              report_q, report_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic              out_valid_q, out_valid_d;
  logic [15:0]       cell_q, cell_d;

  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [15:0]       wd;
  logic [ADDR_W-1:0] ra;
  logic              adv_row;

  assign init_busy_o  = (state_q == ST_FILL) && !report_q;
  assign out_valid_o  = out_valid_q;
  assign cell_value_o = cell_q;
  assign cursor_row_o = 5'(row_q);
  assign cursor_col_o = 7'(col_q);

  // sequencer: command execution, store sweeps and result slot
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    fill_d      = fill_q;
    report_d    = report_q;
    row_d       = row_q;
    col_d       = col_q;
    base_d      = base_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cell_d      = cell_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    wa          = ptr_q;
    wd          = fill_q;
    ra          = ptr_q + ADDR_W'(COLUMNS + 1);
    adv_row     = 1'b0;

    unique case (state_q)
      ST_FILL: begin
        we = 1'b1;
        if (ptr_q == ADDR_W'(CELLS - 1)) begin
          state_d = ST_IDLE;
          if (report_q) begin
            out_valid_d = 1'b1;
            cell_d      = '0;
          end
        end else begin
          ptr_d = ptr_q + ADDR_W'(1);
        end
      end

      ST_PRIME: begin
        // first source cell of the scroll copy
        ra      = ADDR_W'(COLUMNS);
        ptr_d   = '0;
        state_d = ST_COPY;
      end

      ST_COPY: begin
        // move each cell up one row, the registered read fetches the source of the next cell
        we = 1'b1;
        wa = ptr_q;
        wd = rd_data_q;
        if (ptr_q == ADDR_W'(CELLS - COLUMNS - 1)) begin
          ptr_d    = ADDR_W'(CELLS - COLUMNS);
          report_d = 1'b1;
          state_d  = ST_FILL;
        end else begin
          ptr_d = ptr_q + ADDR_W'(1);
        end
      end

      ST_READ: begin
        out_valid_d = 1'b1;
        cell_d      = rd_data_q;
        state_d     = ST_IDLE;
      end

      ST_IDLE: begin
        if (cmd_valid_i && (!out_valid_q || out_ready_i)) begin
          pop_o  = 1'b1;
          cell_d = '0;
          unique case (cmd_i.op)
            tcw_pkg::OP_PUT: begin
              we = 1'b1;
              wa = base_q + ADDR_W'(col_q);
              wd = {cmd_i.color, cmd_i.char_code};
              if (col_q == COL_W'(COLUMNS - 1)) begin
                adv_row = 1'b1;
              end else begin
                col_d       = col_q + COL_W'(1);
                out_valid_d = 1'b1;
              end
            end
            tcw_pkg::OP_NEWLINE: begin
              adv_row = 1'b1;
            end
            tcw_pkg::OP_RETURN: begin
              col_d       = '0;
              out_valid_d = 1'b1;
            end
            tcw_pkg::OP_CLEAR: begin
              fill_d   = {cmd_i.color, tcw_pkg::SPACE_CODE};
              ptr_d    = '0;
              row_d    = '0;
              col_d    = '0;
              base_d   = '0;
              report_d = 1'b1;
              state_d  = ST_FILL;
            end
            tcw_pkg::OP_READ: begin
              if (cmd_i.read_ok) begin
                ra      = ADDR_W'(cmd_i.read_index);
                state_d = ST_READ;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            tcw_pkg::OP_NOP: begin
              out_valid_d = 1'b1;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase

          // next row, scrolling when the cursor leaves the last row
          if (adv_row) begin
            col_d = '0;
            if (row_q == ROW_W'(ROWS - 1)) begin
              fill_d  = {cmd_i.color, tcw_pkg::SPACE_CODE};
              state_d = ST_PRIME;
            end else begin
              row_d       = row_q + ROW_W'(1);
              base_d      = base_q + ADDR_W'(COLUMNS);
              out_valid_d = 1'b1;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers; reset starts the blanking sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      ptr_q       <= '0;
      fill_q      <= tcw_pkg::RESET_BLANK;
      report_q    <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      fill_q      <= fill_d;
      report_q    <= report_d;
      row_q       <= row_d;
      col_q       <= col_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result cell
  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  // screen store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      screen_mem_q[wa] <= wd;
    end
    rd_data_q <= screen_mem_q[ra];
  end

endmodule

@@ dv/tb_text_console_writer_core.sv @@
module tb_text_console_writer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  KIND_PUT     = tcw_pkg::KIND_PUT;
  localparam logic [1:0]  KIND_CLEAR   = tcw_pkg::KIND_CLEAR;
  localparam logic [1:0]  KIND_READ    = tcw_pkg::KIND_READ;
  localparam logic [1:0]  KIND_UNUSED  = tcw_pkg::KIND_UNUSED;
  localparam logic [7:0]  NEWLINE_CODE = tcw_pkg::NEWLINE_CODE;
  localparam logic [7:0]  RETURN_CODE  = tcw_pkg::RETURN_CODE;
  localparam logic [7:0]  SPACE_CODE   = tcw_pkg::SPACE_CODE;
  localparam logic [15:0] RESET_BLANK  = tcw_pkg::RESET_BLANK;

  localparam int unsigned COLUMNS      = 80;
  localparam int unsigned ROWS         = 25;
  localparam int unsigned CELLS        = COLUMNS * ROWS;
  localparam int unsigned RANDOM_ITEMS = 1720;
  localparam int unsigned CYCLE_LIMIT  = 20_000_000;
  // stray result beats are still caught for a while after the drain
  localparam int unsigned SETTLE_CYCLES = CELLS + 100;

  typedef struct packed {
    logic [15:0] value;
    logic [4:0]  row;
    logic [6:0]  col;
  } readout_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [7:0]  attr;
    logic [10:0] idx;
    int unsigned reps;
    bit          typed;
    readout_t    want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [7:0]  char_code_i;
  logic [7:0]  color_i;
  logic [10:0] read_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] cell_value_o;
  logic [4:0]  cursor_row_o;
  logic [6:0]  cursor_col_o;

  // typed expectation riding along with the beat on the input channel
  bit          want_typed;
  readout_t    want_readout;

  // screen and cursor as the block should hold them
  logic [15:0] screen_mirror [CELLS];
  int unsigned mirror_row;
  int unsigned mirror_col;

  readout_t    readouts_due [$];
  int unsigned beats_sent;
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  stim_row_t   directed_rows [27];

  text_console_writer_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .char_code_i (char_code_i),
    .color_i     (color_i),
    .read_index_i(read_index_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cell_value_o(cell_value_o),
    .cursor_row_o(cursor_row_o),
    .cursor_col_o(cursor_col_o)
  );

  // 4 ns clock
  always #2 clk_i = ~clk_i;

  // cursor to next row, scrolling off the last one
  function automatic void line_feed(input logic [7:0] attr);
    mirror_col = 0;
    mirror_row++;
    if (mirror_row >= ROWS) begin
      for (int i = 0; i + COLUMNS < CELLS; i++) screen_mirror[i] = screen_mirror[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_mirror[i] = {attr, SPACE_CODE};
      mirror_row = ROWS - 1;
    end
  endfunction

  // apply one command to the mirror and return what the block reports for it
  function automatic readout_t step_console(input logic [1:0] kind, input logic [7:0] ch,
                                            input logic [7:0] attr, input logic [10:0] idx);
    readout_t r;
    r = '0;
    case (kind)
      KIND_PUT: begin
        if (ch == NEWLINE_CODE) begin
          line_feed(attr);
        end else if (ch == RETURN_CODE) begin
          mirror_col = 0;
        end else begin
          screen_mirror[mirror_row * COLUMNS + mirror_col] = {attr, ch};
          mirror_col++;
          if (mirror_col >= COLUMNS) line_feed(attr);
        end
      end
      KIND_CLEAR: begin
        foreach (screen_mirror[i]) screen_mirror[i] = {attr, SPACE_CODE};
        mirror_row = 0;
        mirror_col = 0;
      end
      KIND_READ: begin
        if (idx < CELLS) r.value = screen_mirror[idx];
      end
      default: begin
      end
    endcase
    r.row = mirror_row[4:0];
    r.col = mirror_col[6:0];
    return r;
  endfunction

  function automatic stim_row_t stim_entry(input logic [1:0] kind, input logic [7:0] ch,
                                           input logic [7:0] attr, input logic [10:0] idx,
                                           input int unsigned reps, input bit typed,
                                           input logic [15:0] cell_v, input logic [4:0] row,
                                           input logic [6:0] col);
    stim_row_t s;
    s.kind  = kind;
    s.ch    = ch;
    s.attr  = attr;
    s.idx   = idx;
    s.reps  = reps;
    s.typed = typed;
    s.want  = '{cell_v, row, col};
    return s;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  // result beats checked first, then the accepted input beat is predicted
  always @(posedge clk_i) begin
    readout_t exp_r;
    readout_t next_r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (readouts_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, got cell %h row %0d col %0d",
                   $time, cell_value_o, cursor_row_o, cursor_col_o);
        end else begin
          exp_r = readouts_due.pop_front();
          check_field("cell_value", exp_r.value, cell_value_o);
          check_field("cursor_row", 16'(exp_r.row), 16'(cursor_row_o));
          check_field("cursor_col", 16'(exp_r.col), 16'(cursor_col_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        next_r = step_console(kind_i, char_code_i, color_i, read_index_i);
        readouts_due.push_back(want_typed ? want_readout : next_r);
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // present one beat at the falling edge and hold it until taken
  task automatic drive_beat(input stim_row_t s);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= s.kind;
    char_code_i  <= s.ch;
    color_i      <= s.attr;
    read_index_i <= s.idx;
    want_typed   <= s.typed;
    want_readout <= s.want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_cmd(input logic [1:0] kind, input logic [7:0] ch,
                          input logic [7:0] attr, input logic [10:0] idx);
    drive_beat(stim_entry(kind, ch, attr, idx, 1, 1'b0, '0, '0, '0));
  endtask

  // mostly cells near the cursor or anywhere on screen, some past the end
  function automatic logic [10:0] pick_read_index();
    int unsigned pick;
    int unsigned spot;
    pick = $urandom_range(0, 7);
    spot = mirror_row * COLUMNS + mirror_col;
    if (pick == 0) return 11'($urandom_range(CELLS, 2047));
    if (pick < 3) return 11'((spot > 3) ? spot - $urandom_range(0, 3) : spot);
    return 11'($urandom_range(0, CELLS - 1));
  endfunction

  // one burst of random traffic, mostly lines of text
  task automatic random_burst();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  attr;
    pick = $urandom_range(0, 99);
    attr = 8'($urandom_range(0, 255));
    if (pick < 55) begin
      // text line: usually short, sometimes long enough to wrap
      len = ($urandom_range(0, 6) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 30);
      repeat (len)
        send_cmd(KIND_PUT, 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : attr,
                 11'($urandom_range(0, 2047)));
      send_cmd(KIND_PUT, ($urandom_range(0, 9) < 7) ? NEWLINE_CODE : RETURN_CODE, attr,
               11'($urandom_range(0, 2047)));
    end else if (pick < 70) begin
      // run of newlines to push the cursor down and scroll
      repeat ($urandom_range(1, 8))
        send_cmd(KIND_PUT, NEWLINE_CODE, 8'($urandom_range(0, 255)),
                 11'($urandom_range(0, 2047)));
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 6))
        send_cmd(KIND_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 pick_read_index());
    end else if (pick < 89) begin
      repeat ($urandom_range(1, 3))
        send_cmd(KIND_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 11'($urandom_range(0, 2047)));
    end else if (pick < 92) begin
      send_cmd(KIND_CLEAR, 8'($urandom_range(0, 255)), attr, 11'($urandom_range(0, 2047)));
    end else begin
      // anything goes
      repeat ($urandom_range(1, 4))
        send_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), pick_read_index());
    end
  endtask

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned random_base;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_PUT;
    char_code_i    = '0;
    color_i        = '0;
    read_index_i   = '0;
    out_ready_i    = 1'b0;
    want_typed     = 1'b0;
    want_readout   = '0;
    beats_sent     = 0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (screen_mirror[i]) screen_mirror[i] = RESET_BLANK;
    mirror_row = 0;
    mirror_col = 0;

    directed_rows = '{
      // blank screen after reset, reads at both ends and past the end
      stim_entry(KIND_READ,   8'h00, 8'h00, 11'd0,    1,  1'b1, RESET_BLANK, 5'd0, 7'd0),
      stim_entry(KIND_READ,   8'hFF, 8'hFF, 11'd1999, 1,  1'b1, RESET_BLANK, 5'd0, 7'd0),
      stim_entry(KIND_READ,   8'h00, 8'h00, 11'd2047, 1,  1'b1, 16'h0000,    5'd0, 7'd0),
      stim_entry(KIND_READ,   8'h00, 8'h00, 11'd2000, 1,  1'b1, 16'h0000,    5'd0, 7'd0),
      // unused kind changes nothing
      stim_entry(KIND_UNUSED, 8'hFF, 8'hFF, 11'd2047, 1,  1'b1, 16'h0000,    5'd0, 7'd0),
      // field extremes on plain puts
      stim_entry(KIND_PUT,    8'h41, 8'h1F, 11'd0,    1,  1'b0, '0, '0, '0),
      stim_entry(KIND_PUT,    8'h00, 8'h00, 11'd2047, 1,  1'b0, '0, '0, '0),
      stim_entry(KIND_PUT,    8'hFF, 8'hFF, 11'd0,    1,  1'b0, '0, '0, '0),
      stim_entry(KIND_READ,   8'h00, 8'h00, 11'd0,    1,  1'b0, '0, '0, '0),
      stim_entry(KIND_READ,   8'h00, 8'h00, 11'd2,    1,  1'b0, '0, '0, '0),
      // carriage return, newline, unused kind with a moved cursor
      stim_entry(KIND_PUT,    RETURN_CODE,  8'h55, 11'd0, 1, 1'b0, '0, '0, '0),
      stim_entry(KIND_PUT,    NEWLINE_CODE, 8'h00, 11'd0, 1, 1'b0, '0, '0, '0),
      stim_entry(KIND_UNUSED, 8'h00, 8'h00, 11'd0,    1,  1'b0, '0, '0, '0),
      // clear homes the cursor and blanks in the given color
      stim_entry(KIND_CLEAR,  8'h00, 8'hFF, 11'd0,    1,  1'b1, 16'h0000, 5'd0, 7'd0),
      stim_entry(KIND_READ,   8'h00, 8'h00, 11'd1234, 1,  1'b1, {8'hFF, SPACE_CODE}, 5'd0, 7'd0),
      // newline down to the last row, then scroll with fill color
      stim_entry(KIND_PUT,    8'h78, 8'h3C, 11'd0,    1,  1'b0, '0, '0, '0),
      stim_entry(KIND_PUT,    NEWLINE_CODE, 8'h4E, 11'd0, 24, 1'b0, '0, '0, '0),
      stim_entry(KIND_PUT,    NEWLINE_CODE, 8'h9A, 11'd0, 1,  1'b0, '0, '0, '0),
      stim_entry(KIND_READ,   8'h00, 8'h00, 11'd1920, 1,  1'b1, {8'h9A, SPACE_CODE}, 5'd24, 7'd0),
      stim_entry(KIND_READ,   8'h00, 8'h00, 11'd0,    1,  1'b0, '0, '0, '0),
      // fill the last row, then wrap past the end and scroll
      stim_entry(KIND_PUT,    8'h57, 8'h71, 11'd0,    79, 1'b0, '0, '0, '0),
      stim_entry(KIND_PUT,    8'h5A, 8'h2B, 11'd0,    1,  1'b0, '0, '0, '0),
      stim_entry(KIND_READ,   8'h00, 8'h00, 11'd1840, 1,  1'b0, '0, '0, '0),
      stim_entry(KIND_READ,   8'h00, 8'h00, 11'd1999, 1,  1'b1, {8'h2B, SPACE_CODE}, 5'd24, 7'd0),
      stim_entry(KIND_PUT,    8'h71, 8'h0E, 11'd0,    5,  1'b0, '0, '0, '0),
      stim_entry(KIND_PUT,    RETURN_CODE, 8'h0E, 11'd0, 1, 1'b0, '0, '0, '0),
      stim_entry(KIND_CLEAR,  8'h00, 8'h00, 11'd0,    1,  1'b1, 16'h0000, 5'd0, 7'd0)
    };

    // reset, released at a falling edge
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (directed_rows[r]) begin
      repeat (directed_rows[r].reps) drive_beat(directed_rows[r]);
    end

    // random traffic in four idling phases
    random_base = beats_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      while (beats_sent < random_base + (phase + 1) * RANDOM_ITEMS / 4) random_burst();
    end
    in_valid_i <= 1'b0;

    // drain, then keep watching for stray result beats
    while (readouts_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
